// ===== hw/rtl/arm_data_processing_alu_unit_macros.svh =====
// Assertion macros shared by the ALU unit RTL.
`ifndef ARM_DATA_PROCESSING_ALU_UNIT_MACROS_SVH
`define ARM_DATA_PROCESSING_ALU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADPALU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adpalu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADPALU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adpalu assertion failed");

`endif

// ===== hw/rtl/adpalu_pkg.sv =====
// Package: types, codes and stage payloads of the data-processing ALU.
`timescale 1ns / 1ps
package adpalu_pkg;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_PSR   = 2'd2
  } status_t;

  // Shift type field, bits 6:5
  typedef enum logic [1:0] {
    KIND_LSL = 2'd0,
    KIND_LSR = 2'd1,
    KIND_ASR = 2'd2,
    KIND_ROR = 2'd3
  } shift_kind_t;

  // Normalized shifter operation produced by decode
  typedef enum logic [2:0] {
    SH_PASS   = 3'd0,  // value through, carry unchanged
    SH_PASS31 = 3'd1,  // value through, carry from bit 31
    SH_LSL    = 3'd2,
    SH_LSR    = 3'd3,
    SH_ASR    = 3'd4,
    SH_ROR    = 3'd5,
    SH_RRX    = 3'd6
  } sh_mode_t;

  localparam logic [3:0] PC_INDEX = 4'd15;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned AMT_W  = 6;   // amounts 0..33 after saturation

  typedef struct packed {
    opcode_t             op;
    logic                s;
    logic [3:0]          rd;
    status_t             status;
    logic [DATA_W-1:0]   rn;
    logic [DATA_W-1:0]   sh_val;
    sh_mode_t            sh_mode;
    logic [AMT_W-1:0]    sh_amt;
    logic [3:0]          flags;
  } dec_t;

  typedef struct packed {
    opcode_t             op;
    logic                s;
    logic [3:0]          rd;
    status_t             status;
    logic [DATA_W-1:0]   rn;
    logic [DATA_W-1:0]   opnd;
    logic                shc;
    logic [3:0]          flags;
  } shf_t;

  typedef struct packed {
    logic [DATA_W-1:0]   result;
    logic                write_result;
    logic [3:0]          dest_index;
    logic [3:0]          flags_out;
    status_t             status;
  } res_t;

endpackage

// ===== hw/rtl/adpalu_ifs.sv =====
// Valid/ready channel interfaces for instruction input and result output.
`timescale 1ns / 1ps
interface adpalu_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] rn_value;
  logic [31:0] rm_value;
  logic [7:0]  rs_low_byte;
  logic [3:0]  flags_in;

  modport source (output valid, instr_word, rn_value, rm_value, rs_low_byte, flags_in,
                  input ready);
  modport sink   (input valid, instr_word, rn_value, rm_value, rs_low_byte, flags_in,
                  output ready);
endinterface

interface adpalu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        write_result;
  logic [3:0]  dest_index;
  logic [3:0]  flags_out;
  logic [1:0]  status;

  modport source (output valid, result, write_result, dest_index, flags_out, status,
                  input ready);
  modport sink   (input valid, result, write_result, dest_index, flags_out, status,
                  output ready);
endinterface

// ===== hw/rtl/adpalu_decode.sv =====
// Stage 1: field decode, exception checks, PC offset and shifter setup.
`timescale 1ns / 1ps
module adpalu_decode
  import adpalu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [31:0]  instr_word,
  input  logic [31:0]  rn_value,
  input  logic [31:0]  rm_value,
  input  logic [7:0]   rs_low_byte,
  input  logic [3:0]   flags_in,
  input  logic         dn_ready,
  output logic         vld,
  output dec_t         q
);

  dec_t        d;
  logic        imm;
  logic        regsh;
  logic [4:0]  rot;
  logic [4:0]  iamt;
  shift_kind_t kind;

  always_comb begin
    imm   = instr_word[25];
    regsh = !imm && instr_word[4];
    kind  = shift_kind_t'(instr_word[6:5]);
    rot   = {instr_word[11:8], 1'b0};
    iamt  = instr_word[11:7];

    d.op    = opcode_t'(instr_word[24:21]);
    d.s     = instr_word[20];
    d.rd    = instr_word[15:12];
    d.flags = flags_in;

    if ((d.rd == PC_INDEX && d.s) || (regsh && instr_word[7])) begin
      d.status = ST_UNDEF;
    end else if (!d.s && (d.op == OP_TST || d.op == OP_TEQ ||
                          d.op == OP_CMP || d.op == OP_CMN)) begin
      d.status = ST_PSR;
    end else begin
      d.status = ST_OK;
    end

    // PC reads ahead: +8 with a register shift, +4 otherwise
    if (instr_word[19:16] == PC_INDEX) begin
      d.rn = rn_value + (regsh ? 32'd8 : 32'd4);
    end else begin
      d.rn = rn_value;
    end

    d.sh_mode = SH_PASS;
    d.sh_amt  = '0;
    if (imm) begin
      d.sh_val = {24'b0, instr_word[7:0]};
      if (rot != 5'd0) begin
        d.sh_mode = SH_ROR;
        d.sh_amt  = {1'b0, rot};
      end
    end else if (regsh) begin
      d.sh_val = rm_value;
      if (rs_low_byte != 8'd0) begin
        unique case (kind)
          KIND_LSL: begin
            d.sh_mode = SH_LSL;
            d.sh_amt  = (rs_low_byte > 8'd32) ? 6'd33 : rs_low_byte[5:0];
          end
          KIND_LSR: begin
            d.sh_mode = SH_LSR;
            d.sh_amt  = (rs_low_byte > 8'd32) ? 6'd33 : rs_low_byte[5:0];
          end
          KIND_ASR: begin
            d.sh_mode = SH_ASR;
            d.sh_amt  = (rs_low_byte > 8'd32) ? 6'd32 : rs_low_byte[5:0];
          end
          KIND_ROR: begin
            if (rs_low_byte[4:0] == 5'd0) begin
              d.sh_mode = SH_PASS31;
            end else begin
              d.sh_mode = SH_ROR;
              d.sh_amt  = {1'b0, rs_low_byte[4:0]};
            end
          end
          default: d.sh_mode = SH_PASS;
        endcase
      end
    end else begin
      d.sh_val = rm_value;
      unique case (kind)
        KIND_LSL: begin
          if (iamt != 5'd0) begin
            d.sh_mode = SH_LSL;
            d.sh_amt  = {1'b0, iamt};
          end
        end
        KIND_LSR: begin
          d.sh_mode = SH_LSR;
          d.sh_amt  = (iamt == 5'd0) ? 6'd32 : {1'b0, iamt};
        end
        KIND_ASR: begin
          d.sh_mode = SH_ASR;
          d.sh_amt  = (iamt == 5'd0) ? 6'd32 : {1'b0, iamt};
        end
        KIND_ROR: begin
          if (iamt == 5'd0) begin
            d.sh_mode = SH_RRX;
          end else begin
            d.sh_mode = SH_ROR;
            d.sh_amt  = {1'b0, iamt};
          end
        end
        default: d.sh_mode = SH_PASS;
      endcase
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/adpalu_shift.sv =====
// Stage 2: barrel shifter forming the second operand and shifter carry.
`timescale 1ns / 1ps
module adpalu_shift
  import adpalu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  dec_t  d,
  input  logic  dn_ready,
  output logic  vld,
  output shf_t  q
);

  shf_t               n;
  logic [65:0]        lsl_w;
  logic [32:0]        lsr_w;
  logic signed [32:0] asr_w;
  logic [63:0]        ror_w;
  logic               cin;

  always_comb begin
    cin   = d.flags[1];
    lsl_w = {34'b0, d.sh_val} << d.sh_amt;
    lsr_w = {d.sh_val, 1'b0} >> d.sh_amt;
    asr_w = $signed({d.sh_val, 1'b0}) >>> d.sh_amt;
    ror_w = {d.sh_val, d.sh_val} >> d.sh_amt[4:0];

    n.op     = d.op;
    n.s      = d.s;
    n.rd     = d.rd;
    n.status = d.status;
    n.rn     = d.rn;
    n.flags  = d.flags;

    case (d.sh_mode)
      SH_PASS31: begin n.opnd = d.sh_val;       n.shc = d.sh_val[31]; end
      SH_LSL:    begin n.opnd = lsl_w[31:0];    n.shc = lsl_w[32];    end
      SH_LSR:    begin n.opnd = lsr_w[32:1];    n.shc = lsr_w[0];     end
      SH_ASR:    begin n.opnd = asr_w[32:1];    n.shc = asr_w[0];     end
      SH_ROR:    begin n.opnd = ror_w[31:0];    n.shc = ror_w[31];    end
      SH_RRX:    begin n.opnd = {cin, d.sh_val[31:1]}; n.shc = d.sh_val[0]; end
      default:   begin n.opnd = d.sh_val;       n.shc = cin;          end
    endcase
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      q <= n;
    end
  end

endmodule

// ===== hw/rtl/adpalu_exec.sv =====
// Stage 3: opcode execution, flag update and output register.
`timescale 1ns / 1ps
module adpalu_exec
  import adpalu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  shf_t  d,
  input  logic  dn_ready,
  output logic  vld,
  output res_t  q
);

  res_t        n;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] bb;
  logic        sub;
  logic        ci;
  logic [32:0] sum;
  logic [31:0] res;
  logic        c;
  logic        v;

  always_comb begin
    // reverse subtracts swap the operands
    if (d.op == OP_RSB || d.op == OP_RSC) begin
      a = d.opnd;
      b = d.rn;
    end else begin
      a = d.rn;
      b = d.opnd;
    end
    sub = (d.op == OP_SUB || d.op == OP_RSB || d.op == OP_SBC ||
           d.op == OP_RSC || d.op == OP_CMP);
    bb  = sub ? ~b : b;

    unique case (d.op) inside
      OP_SUB, OP_RSB, OP_CMP:  ci = 1'b1;
      OP_ADD, OP_CMN:          ci = 1'b0;
      default:                 ci = d.flags[1];
    endcase

    sum = {1'b0, a} + {1'b0, bb} + {32'b0, ci};

    c = d.shc;
    v = d.flags[0];
    unique case (d.op) inside
      OP_AND, OP_TST: res = d.rn & d.opnd;
      OP_EOR, OP_TEQ: res = d.rn ^ d.opnd;
      OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC, OP_CMP, OP_CMN: begin
        res = sum[31:0];
        c   = sum[32];
        v   = ~(a[31] ^ bb[31]) & (a[31] ^ sum[31]);
      end
      OP_ORR:         res = d.rn | d.opnd;
      OP_MOV:         res = d.opnd;
      OP_BIC:         res = d.rn & ~d.opnd;
      default:        res = ~d.opnd;
    endcase

    n.dest_index = d.rd;
    n.status     = d.status;
    if (d.status != ST_OK) begin
      n.result       = '0;
      n.write_result = 1'b0;
      n.flags_out    = d.flags;
    end else begin
      n.result       = res;
      n.write_result = !(d.op == OP_TST || d.op == OP_TEQ ||
                         d.op == OP_CMP || d.op == OP_CMN);
      n.flags_out    = d.s ? {res[31], (res == 32'd0), c, v} : d.flags;
    end
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      q <= n;
    end
  end

endmodule

// ===== hw/rtl/arm_data_processing_alu_unit.sv =====
// Top level of the ARM data-processing ALU with barrel shifter.
// Executes one decoded, condition-passed ARM data-processing instruction per
// transfer on req and returns one result transfer on rsp. The unit is a
// three-stage pipeline: decode (exception checks, PC read-ahead add, shifter
// setup), barrel shift (second operand and shifter carry), and execute
// (32-bit add/logic, NZCV, output register). A result passes through the
// decode, shift and execute registers before it shows on rsp. A new
// instruction can be taken every cycle: each stage loads whenever it is
// empty or the stage after it moves, so throughput is one per clock and
// only rsp back-pressure slows it. Every stage holds its own
// valid bit and ready is formed per stage, so a stalled rsp fills the
// pipeline's bubbles first and req only backs up once all three stages hold
// work. Status 1 marks undefined encodings (S with PC destination, or bit 7
// set with a register shift), status 2 marks TST/TEQ/CMP/CMN without S
// (PSR transfer, not handled here); both give a zero result, no write and
// unchanged flags.
`timescale 1ns / 1ps
`include "arm_data_processing_alu_unit_macros.svh"
module arm_data_processing_alu_unit
  import adpalu_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  adpalu_req_if.sink     req,
  adpalu_rsp_if.source   rsp
);

  // stage handshakes
  logic  dec_vld;
  logic  shf_vld;
  logic  exe_vld;
  logic  shf_rdy;
  logic  exe_rdy;
  dec_t  dec_q;
  shf_t  shf_q;
  res_t  exe_q;

  // Stage 1: decode
  adpalu_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (req.valid),
    .up_ready    (req.ready),
    .instr_word  (req.instr_word),
    .rn_value    (req.rn_value),
    .rm_value    (req.rm_value),
    .rs_low_byte (req.rs_low_byte),
    .flags_in    (req.flags_in),
    .dn_ready    (shf_rdy),
    .vld         (dec_vld),
    .q           (dec_q)
  );

  // Stage 2: barrel shifter
  adpalu_shift u_shift (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_vld),
    .up_ready (shf_rdy),
    .d        (dec_q),
    .dn_ready (exe_rdy),
    .vld      (shf_vld),
    .q        (shf_q)
  );

  // Stage 3: execute; its register is the output register
  adpalu_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .up_valid (shf_vld),
    .up_ready (exe_rdy),
    .d        (shf_q),
    .dn_ready (rsp.ready),
    .vld      (exe_vld),
    .q        (exe_q)
  );

  assign rsp.valid        = exe_vld;
  assign rsp.result       = exe_q.result;
  assign rsp.write_result = exe_q.write_result;
  assign rsp.dest_index   = exe_q.dest_index;
  assign rsp.flags_out    = exe_q.flags_out;
  assign rsp.status       = exe_q.status;

  // A req transfer always lands in the decode stage.
  `ADPALU_ASSERT_NEXT(a_req_lands, clk, rst, req.valid && req.ready, dec_vld)

  // Work held in decode is never dropped while the shifter stalls.
  `ADPALU_ASSERT_NEXT(a_dec_holds, clk, rst, dec_vld && !shf_rdy, dec_vld && $stable(dec_q))

  // Only a good instruction writes a register.
  `ADPALU_ASSERT_SAME(a_write_ok, clk, rst, rsp.valid && rsp.write_result,
                      rsp.status == ST_OK)

  // Exceptional results carry a zero result.
  `ADPALU_ASSERT_SAME(a_exc_zero, clk, rst, rsp.valid && rsp.status != ST_OK,
                      rsp.result == 32'd0)

endmodule

// ===== bench/tb_arm_data_processing_alu_unit.sv =====
// Self-checking testbench for the ARM data-processing ALU unit.
`timescale 1ns / 1ps
module tb_arm_data_processing_alu_unit;
  import adpalu_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The longest legal quiet stretch is the long receiver hold (LONG_HOLD) plus
  // the trip through the pipeline registers, so this leaves a wide margin.
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD  = 80;
  localparam int unsigned RAND_ITEMS = 1550;

  // Expected-result tracking. Prediction is a plain reimplementation of the
  // data-processing execute step: operand 2 formation, ALU op, NZCV update.
  class dp_scoreboard;
    res_t        expected_q[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    // Returns {carry, value} of the shifted register operand.
    static function logic [32:0] barrel_shift(logic [31:0] iw, logic [31:0] val,
                                              logic [7:0] rs, logic cin);
      shift_kind_t kind;
      int unsigned amt;
      logic        c;
      logic [31:0] r;
      kind = shift_kind_t'(iw[6:5]);
      c = cin;
      if (iw[4]) begin
        amt = rs;
        if (amt == 0) return {c, val};
        if (kind == KIND_ROR) begin
          amt = rs[4:0];
          if (amt == 0) return {val[31], val};
        end
      end else begin
        amt = iw[11:7];
        if (amt == 0) begin
          if (kind == KIND_LSL) return {c, val};
          if (kind == KIND_ROR) return {val[0], c, val[31:1]};  // RRX
          amt = 32;
        end
      end
      case (kind)
        KIND_LSL: begin
          if (amt < 32) begin
            c = val[32-amt];
            r = val << amt;
          end else begin
            c = (amt == 32) ? val[0] : 1'b0;
            r = '0;
          end
        end
        KIND_LSR: begin
          if (amt < 32) begin
            c = val[amt-1];
            r = val >> amt;
          end else begin
            c = (amt == 32) ? val[31] : 1'b0;
            r = '0;
          end
        end
        KIND_ASR: begin
          if (amt < 32) begin
            c = val[amt-1];
            r = $signed(val) >>> amt;
          end else begin
            c = val[31];
            r = {32{val[31]}};
          end
        end
        default: begin
          c = val[amt-1];
          r = (val >> amt) | (val << (32 - amt));
        end
      endcase
      return {c, r};
    endfunction

    // a + b + cin or a - b - !cin; returns {carry, overflow, sum}.
    static function logic [33:0] add_carry(logic [31:0] a, logic [31:0] b, logic sub,
                                           logic cin);
      logic [31:0] bb;
      logic [32:0] sum;
      logic        v;
      bb  = sub ? ~b : b;
      sum = {1'b0, a} + {1'b0, bb} + {32'd0, cin};
      v   = ~(a[31] ^ bb[31]) & (a[31] ^ sum[31]);
      return {sum[32], v, sum[31:0]};
    endfunction

    static function res_t execute_dp(logic [31:0] iw, logic [31:0] rn, logic [31:0] rm,
                                     logic [7:0] rs, logic [3:0] fl);
      res_t        o;
      opcode_t     op;
      logic        imm, regsh, s, c, v, cin;
      logic [4:0]  rot;
      logic [31:0] opnd, rn_eff, res;
      logic [32:0] sh;
      logic [33:0] sum;
      op    = opcode_t'(iw[24:21]);
      imm   = iw[25];
      regsh = !imm && iw[4];
      s     = iw[20];
      c     = fl[1];
      v     = fl[0];
      cin   = fl[1];
      o.result       = '0;
      o.write_result = 1'b0;
      o.dest_index   = iw[15:12];
      o.flags_out    = fl;
      o.status       = ST_OK;
      if ((iw[15:12] == PC_INDEX && s) || (regsh && iw[7])) begin
        o.status = ST_UNDEF;
        return o;
      end
      if (op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN} && !s) begin
        o.status = ST_PSR;
        return o;
      end
      // PC reads ahead: +8 with a register shift, +4 otherwise
      rn_eff = (iw[19:16] == PC_INDEX) ? rn + (regsh ? 32'd8 : 32'd4) : rn;
      if (imm) begin
        rot  = {iw[11:8], 1'b0};
        opnd = {24'd0, iw[7:0]};
        if (rot != 0) begin
          opnd = (opnd >> rot) | (opnd << (6'd32 - rot));
          c    = opnd[31];
        end
      end else begin
        sh   = barrel_shift(iw, rm, rs, c);
        c    = sh[32];
        opnd = sh[31:0];
      end
      sum = '0;
      case (op)
        OP_AND, OP_TST: res = rn_eff & opnd;
        OP_EOR, OP_TEQ: res = rn_eff ^ opnd;
        OP_SUB, OP_CMP: sum = add_carry(rn_eff, opnd, 1'b1, 1'b1);
        OP_RSB:         sum = add_carry(opnd, rn_eff, 1'b1, 1'b1);
        OP_ADD, OP_CMN: sum = add_carry(rn_eff, opnd, 1'b0, 1'b0);
        OP_ADC:         sum = add_carry(rn_eff, opnd, 1'b0, cin);
        OP_SBC:         sum = add_carry(rn_eff, opnd, 1'b1, cin);
        OP_RSC:         sum = add_carry(opnd, rn_eff, 1'b1, cin);
        OP_ORR:         res = rn_eff | opnd;
        OP_MOV:         res = opnd;
        OP_BIC:         res = rn_eff & ~opnd;
        default:        res = ~opnd;
      endcase
      if (op inside {OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC, OP_CMP, OP_CMN}) begin
        res = sum[31:0];
        c   = sum[33];
        v   = sum[32];
      end
      o.result       = res;
      o.write_result = !(op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
      if (s) o.flags_out = {res[31], res == 32'd0, c, v};
      return o;
    endfunction

    function void note_issue(logic [31:0] iw, logic [31:0] rn, logic [31:0] rm,
                             logic [7:0] rs, logic [3:0] fl);
      expected_q.push_back(execute_dp(iw, rn, rm, rs, fl));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %h, actual %h", name, want, got);
        error_count++;
      end
    endfunction

    function void check_retire(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("result", want.result, got.result);
      compare_field("write_result", 32'(want.write_result), 32'(got.write_result));
      compare_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
      compare_field("flags_out", 32'(want.flags_out), 32'(got.flags_out));
      compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  adpalu_req_if req_ch ();
  adpalu_rsp_if rsp_ch ();

  arm_data_processing_alu_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #6 clk = ~clk;

  dp_scoreboard sb = new();

  // Traffic shaping knobs, changed per phase by the main sequence.
  bit src_gaps_on;
  bit rsp_stalls_on;
  bit long_hold_req;

  // Instruction word builders.
  function automatic logic [31:0] dp_word(opcode_t op, logic s, logic i, logic [3:0] rn_i,
                                          logic [3:0] rd, logic [11:0] op2);
    return {4'hE, 2'b00, i, op, s, rn_i, rd, op2};
  endfunction

  function automatic logic [11:0] imm_op2(logic [3:0] rot, logic [7:0] imm8);
    return {rot, imm8};
  endfunction

  function automatic logic [11:0] shimm_op2(logic [4:0] amt, shift_kind_t kind,
                                            logic [3:0] rm_i);
    return {amt, kind, 1'b0, rm_i};
  endfunction

  function automatic logic [11:0] shreg_op2(logic [3:0] rs_i, logic bit7, shift_kind_t kind,
                                            logic [3:0] rm_i);
    return {rs_i, bit7, kind, 1'b1, rm_i};
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Offer one instruction and hold it until the unit takes it.
  task automatic send_item(logic [31:0] iw, logic [31:0] rn, logic [31:0] rm,
                           logic [7:0] rs, logic [3:0] fl);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.instr_word  <= iw;
    req_ch.rn_value    <= rn;
    req_ch.rm_value    <= rm;
    req_ch.rs_low_byte <= rs;
    req_ch.flags_in    <= fl;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_issue(iw, rn, rm, rs, fl);
  endtask

  // Mostly well-formed data-processing words with random content; some raw noise.
  task automatic send_random_item();
    logic [31:0] iw, rn, rm;
    logic [7:0]  rs;
    logic [3:0]  fl, rn_i, rd;
    logic [11:0] op2;
    opcode_t     op;
    logic        s, i;
    op   = opcode_t'($urandom_range(0, 15));
    s    = $urandom_range(0, 9) != 0;
    rn_i = ($urandom_range(0, 7) == 0) ? PC_INDEX : 4'($urandom);
    rd   = ($urandom_range(0, 11) == 0) ? PC_INDEX : 4'($urandom);
    i    = 1'b0;
    case ($urandom_range(0, 2))
      0: begin
        i   = 1'b1;
        op2 = 12'($urandom);
      end
      1: op2 = shimm_op2(($urandom_range(0, 4) == 0) ? 5'd0 : 5'($urandom),
                         shift_kind_t'($urandom_range(0, 3)), 4'($urandom));
      default: op2 = shreg_op2(4'($urandom), $urandom_range(0, 9) == 0,
                               shift_kind_t'($urandom_range(0, 3)), 4'($urandom));
    endcase
    iw = dp_word(op, s, i, rn_i, rd, op2);
    iw[31:26] = 6'($urandom);  // ignored by the unit
    if ($urandom_range(0, 7) == 0) iw = $urandom;
    case ($urandom_range(0, 9))
      0:       rs = 8'd0;
      1:       rs = 8'd32;
      2:       rs = 8'($urandom_range(1, 7) * 32);
      3, 4, 5: rs = 8'($urandom_range(1, 31));
      default: rs = 8'($urandom_range(33, 255));
    endcase
    rn = pick_operand();
    rm = pick_operand();
    fl = 4'($urandom);
    send_item(iw, rn, rm, rs, fl);
  endtask

  // Result side: checks each transfer and drives ready with random stall bursts
  // and, on request, one long hold so the pipeline fills and req backs up.
  initial begin
    int unsigned stall_left;
    res_t        got;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.result       = rsp_ch.result;
        got.write_result = rsp_ch.write_result;
        got.dest_index   = rsp_ch.dest_index;
        got.flags_out    = rsp_ch.flags_out;
        got.status       = status_t'(rsp_ch.status);
        sb.check_retire(got);
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Hang detector: no transfer on either side for too long ends the run.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.instr_word  <= '0;
    req_ch.rn_value    <= '0;
    req_ch.rm_value    <= '0;
    req_ch.rs_low_byte <= '0;
    req_ch.flags_in    <= '0;
    src_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    long_hold_req = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every opcode, field extremes, shifter corner cases,
    // PC read-ahead, undefined encodings and PSR transfers.
    send_item(dp_word(OP_AND, 1, 0, 4'd0, 4'd0, shimm_op2(5'd0, KIND_LSL, 4'd1)),
              32'h0, 32'h0, 8'h00, 4'h0);
    send_item(dp_word(OP_EOR, 1, 0, 4'd1, 4'd2, shimm_op2(5'd0, KIND_ASR, 4'd1)),
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF);
    send_item(dp_word(OP_SUB, 1, 1, 4'd2, 4'd3, imm_op2(4'd0, 8'hFF)),
              32'h0, 32'h0, 8'h00, 4'h0);
    send_item(dp_word(OP_RSB, 1, 1, 4'd3, 4'd4, imm_op2(4'd1, 8'h81)),
              32'h5, 32'h0, 8'h00, 4'h0);
    // register LSL by exactly 32 and by 33
    send_item(dp_word(OP_ADD, 1, 0, 4'd4, 4'd5, shreg_op2(4'd2, 0, KIND_LSL, 4'd3)),
              32'h7FFF_FFFF, 32'h1, 8'd32, 4'h0);
    send_item(dp_word(OP_ADC, 1, 0, 4'd5, 4'd6, shreg_op2(4'd2, 0, KIND_LSL, 4'd3)),
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd33, 4'h2);
    // register LSR by exactly 32 and far above
    send_item(dp_word(OP_SBC, 1, 0, 4'd6, 4'd7, shreg_op2(4'd2, 0, KIND_LSR, 4'd3)),
              32'h8000_0000, 32'h8000_0000, 8'd32, 4'h0);
    send_item(dp_word(OP_RSC, 1, 0, 4'd7, 4'd8, shreg_op2(4'd2, 0, KIND_LSR, 4'd3)),
              32'h0, 32'hFFFF_FFFF, 8'd200, 4'h2);
    // register ASR above 32, ROR by a multiple of 32
    send_item(dp_word(OP_TST, 1, 0, 4'd8, 4'd9, shreg_op2(4'd2, 0, KIND_ASR, 4'd3)),
              32'hFFFF_FFFF, 32'h8000_0001, 8'd40, 4'h0);
    send_item(dp_word(OP_TEQ, 1, 0, 4'd9, 4'd10, shreg_op2(4'd2, 0, KIND_ROR, 4'd3)),
              32'h0, 32'h8000_0000, 8'd64, 4'h0);
    // register shift by zero keeps carry
    send_item(dp_word(OP_CMP, 1, 0, 4'd10, 4'd11, shreg_op2(4'd2, 0, KIND_LSL, 4'd3)),
              32'h1234_5678, 32'h1234_5678, 8'd0, 4'h2);
    // immediate ROR #0 is RRX; immediate LSR #0 shifts by 32
    send_item(dp_word(OP_CMN, 1, 0, 4'd11, 4'd12, shimm_op2(5'd0, KIND_ROR, 4'd3)),
              32'h0, 32'h1, 8'd0, 4'h2);
    send_item(dp_word(OP_ORR, 1, 0, 4'd12, 4'd13, shimm_op2(5'd0, KIND_LSR, 4'd3)),
              32'h0, 32'h8000_0000, 8'd0, 4'h0);
    send_item(dp_word(OP_MOV, 1, 0, 4'd13, 4'd14, shreg_op2(4'd2, 0, KIND_ROR, 4'd3)),
              32'h0, 32'h0000_00FF, 8'd7, 4'h0);
    // PC as Rn, immediate operand: reads +4
    send_item(dp_word(OP_BIC, 1, 1, PC_INDEX, 4'd1, imm_op2(4'd15, 8'hFF)),
              32'hFFFF_FFFC, 32'h0, 8'd0, 4'h0);
    // PC destination without S is legal
    send_item(dp_word(OP_MVN, 0, 1, 4'd0, PC_INDEX, imm_op2(4'd4, 8'h01)),
              32'h0, 32'h0, 8'd0, 4'hA);
    // PC as Rn with register shift: reads +8, wraps
    send_item(dp_word(OP_ADD, 1, 0, PC_INDEX, 4'd2, shreg_op2(4'd2, 0, KIND_LSR, 4'd3)),
              32'hFFFF_FFF8, 32'h10, 8'd4, 4'h0);
    // undefined: S with PC destination; bit 7 with register shift
    send_item(dp_word(OP_ADD, 1, 1, 4'd1, PC_INDEX, imm_op2(4'd0, 8'h01)),
              32'h1, 32'h1, 8'd1, 4'h5);
    send_item(dp_word(OP_MOV, 0, 0, 4'd1, 4'd3, shreg_op2(4'd2, 1, KIND_LSL, 4'd3)),
              32'h1, 32'h1, 8'd1, 4'h9);
    // compares without S are PSR transfers
    send_item(dp_word(OP_TST, 0, 0, 4'd1, 4'd3, shimm_op2(5'd3, KIND_LSL, 4'd3)),
              32'h1, 32'h1, 8'd1, 4'h6);
    send_item(dp_word(OP_CMN, 0, 1, 4'd1, 4'd3, imm_op2(4'd0, 8'h01)),
              32'h1, 32'h1, 8'd1, 4'h3);
    // ignored top bits set, largest immediate shift amounts
    send_item(dp_word(OP_SUB, 1, 0, 4'd1, 4'd3, shimm_op2(5'd31, KIND_ASR, 4'd3))
              | 32'hFC00_0000, 32'h8000_0000, 32'h8000_0000, 8'd0, 4'h0);
    send_item(dp_word(OP_RSB, 1, 0, 4'd1, 4'd3, shimm_op2(5'd31, KIND_LSL, 4'd3)),
              32'h0, 32'h0000_0001, 8'd0, 4'h0);

    // Back-pressure: hold the result side for a long stretch while the source
    // keeps offering, so every stage fills and req stalls.
    src_gaps_on   = 1'b0;
    long_hold_req = 1'b1;
    repeat (40) send_random_item();

    // Random phases with varying traffic shape; the final phase runs clean.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case (n / 250)
        0:       begin src_gaps_on = 1'b1; rsp_stalls_on = 1'b1; end
        1:       begin src_gaps_on = 1'b0; rsp_stalls_on = 1'b0; end
        2:       begin src_gaps_on = 1'b1; rsp_stalls_on = 1'b0; end
        3:       begin src_gaps_on = 1'b0; rsp_stalls_on = 1'b1; end
        4:       begin src_gaps_on = 1'b1; rsp_stalls_on = 1'b1; end
        default: begin src_gaps_on = 1'b0; rsp_stalls_on = 1'b0; end
      endcase
      send_random_item();
    end
    req_ch.valid <= 1'b0;

    // Drain, then allow for pipeline latency before the verdict.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
